// File: design/sse_pkg.sv
// ----------------------------------------------------------------------------
// sse_pkg: shared types and constants for the sample statistics engine
// Holds statistic codes and the divider request and response types.
// ----------------------------------------------------------------------------
package sse_pkg;
  localparam logic [2:0] STAT_COUNT  = 3'd0;
  localparam logic [2:0] STAT_MIN    = 3'd1;
  localparam logic [2:0] STAT_MAX    = 3'd2;
  localparam logic [2:0] STAT_MEAN   = 3'd3;
  localparam logic [2:0] STAT_MEDIAN = 3'd4;
  localparam logic [2:0] STAT_P90    = 3'd5;
  localparam logic [2:0] STAT_P95    = 3'd6;
  localparam logic [2:0] STAT_STDDEV = 3'd7;

  // divider request/response between sequencer and shared divider
  typedef struct packed {
    logic         go;
    logic [127:0] dividend;
    logic [31:0]  divisor;
  } sse_div_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] quotient;
  } sse_div_rsp_t;
endpackage

// File: design/sse_divider.sv
// ----------------------------------------------------------------------------
// sse_divider: shared restoring divider
// One quotient bit per cycle, 128-bit dividend by 32-bit divisor.
// ----------------------------------------------------------------------------
module sse_divider import sse_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  sse_div_req_t req,
  output sse_div_rsp_t rsp
);
  logic [127:0] quo;
  logic [31:0]  rem;
  logic [31:0]  dvs;
  logic [7:0]   cnt;
  logic         active;
  logic         finished;
  logic [32:0]  trial;

  assign trial = {rem, quo[127]};

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      finished <= 1'b0;
    end else begin
      finished <= 1'b0;
      if (req.go) begin
        active <= 1'b1;
        quo    <= req.dividend;
        dvs    <= req.divisor;
        rem    <= '0;
        cnt    <= 8'd128;
      end else if (active) begin
        // shift in one dividend bit, subtract if it fits
        if (trial >= {1'b0, dvs}) begin
          rem <= 32'(trial - {1'b0, dvs});
          quo <= {quo[126:0], 1'b1};
        end else begin
          rem <= trial[31:0];
          quo <= {quo[126:0], 1'b0};
        end
        cnt <= cnt - 8'd1;
        if (cnt == 8'd1) begin
          active   <= 1'b0;
          finished <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: finished, quotient: quo};
endmodule

// File: design/sample_statistics_engine_top.sv
// ----------------------------------------------------------------------------
// sample_statistics_engine_top: order statistics over a loaded sample set
// Loads samples, sorts them by insertion, then emits eight statistics.
// ----------------------------------------------------------------------------
//  channel | signals                                         | handshake
//  input   | sample_value, sample_valid, set_end             | start & !busy
//  result  | stat_kind, stat_value, overflowed, final_stat   | strobe, no stall
//
// A closing item keeps busy high for the sort (an insertion sort over the
// store: one compare and one move per cycle on one read and one write port),
// then six reads of order statistics, three divisions on the shared divider
// (mean, then the variance numerator over n twice), a 32-step square root,
// and the eight results on consecutive cycles. Busy drops with the last
// result. The receiver cannot stall. Synchronous reset clears count, sums and
// the sequencer; the store needs no clearing.
// ----------------------------------------------------------------------------
module sample_statistics_engine_top import sse_pkg::*; #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] sample_value,
  input  logic        sample_valid,
  input  logic        set_end,
  output logic        strobe,
  output logic [2:0]  stat_kind,
  output logic [31:0] stat_value,
  output logic        overflowed,
  output logic        final_stat
);
  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SW = 32 + AW;
  localparam int QW = 64 + AW;
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_OUTER  = 4'd1;   // pick next element to insert
  localparam logic [3:0] S_RDKEY  = 4'd2;
  localparam logic [3:0] S_CMP    = 4'd3;   // compare store[j-1] against key
  localparam logic [3:0] S_PICK   = 4'd4;   // read order statistics
  localparam logic [3:0] S_PWAIT  = 4'd5;
  localparam logic [3:0] S_MEAN   = 4'd6;
  localparam logic [3:0] S_VAR1   = 4'd7;
  localparam logic [3:0] S_VAR2   = 4'd8;
  localparam logic [3:0] S_SQRT   = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;
  localparam logic [3:0] S_VAR3   = 4'd11;

  logic [31:0] mem [MAX_SAMPLES];
  logic [31:0] rdata;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;

  logic [3:0]  state;
  logic [CW-1:0] count;
  logic [SW-1:0] vsum;
  logic [QW-1:0] qsum;
  logic          ovf;
  logic [CW-1:0] i, j;
  logic [31:0]   key;
  logic [2:0]    pidx;
  logic [31:0]   vmin, vmax, vmed_a, vmed_b, v90, v95, vmean;
  logic [63:0]   var_v;
  logic [31:0]   root;
  logic [4:0]    step;
  logic [2:0]    kind;

  sse_div_req_t dreq;
  sse_div_rsp_t drsp;

  sse_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // simple dual-port store: one read and one write port, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // percentile indices: divide by ten through a reciprocal multiply
  logic [CW+4:0] n9, n19;
  logic [CW-1:0] i90, i95, imid;
  logic [63:0]   q90, q95;
  assign n9   = (CW+5)'(count) * (CW+5)'(9);
  assign n19  = (CW+5)'(count) * (CW+5)'(19);
  assign imid = count >> 1;
  assign q90  = 64'(n9) * 64'(RECIP10);
  assign q95  = 64'(n19 >> 1) * 64'(RECIP10);
  always_comb begin
    i90 = CW'(q90 >> 35);
    i95 = CW'(q95 >> 35);
    if (i90 >= count) i90 = count - CW'(1);
    if (i95 >= count) i95 = count - CW'(1);
  end

  logic [CW-1:0] pick_addr;
  always_comb begin
    case (pidx)
      3'd0:    pick_addr = '0;
      3'd1:    pick_addr = count - CW'(1);
      3'd2:    pick_addr = imid - CW'(1);
      3'd3:    pick_addr = imid;
      3'd4:    pick_addr = i90;
      default: pick_addr = i95;
    endcase
  end

  // variance numerator: n*sum(x^2) - sum(x)^2, built with narrow products
  logic [127:0] nq, s2, diff;
  logic [95:0]  qpad;
  logic [47:0]  vpad;
  logic [63:0]  nq0, nq1, nq2;
  logic [47:0]  s2_ll, s2_x, s2_hh;
  assign qpad  = 96'(qsum);
  assign vpad  = 48'(vsum);
  assign nq0   = 64'(qpad[31:0]) * 64'(count);
  assign nq1   = 64'(qpad[63:32]) * 64'(count);
  assign nq2   = 64'(qpad[95:64]) * 64'(count);
  assign nq    = 128'(nq0) + (128'(nq1) << 32) + (128'(nq2) << 64);
  assign s2_ll = 48'(vpad[23:0]) * 48'(vpad[23:0]);
  assign s2_x  = 48'(vpad[23:0]) * 48'(vpad[47:24]);
  assign s2_hh = 48'(vpad[47:24]) * 48'(vpad[47:24]);
  assign s2    = 128'(s2_ll) + (128'(s2_x) << 25) + (128'(s2_hh) << 48);
  assign diff  = nq - s2;

  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = key;
    dreq  = '0;
    if (accept && sample_valid && count < CW'(MAX_SAMPLES)) begin
      we    = 1'b1;
      waddr = AW'(count);
      wdata = sample_value;
    end
    case (state)
      S_OUTER: raddr = AW'(i);
      S_RDKEY: raddr = AW'(j - CW'(1));
      S_CMP: begin
        raddr = AW'(j - CW'(2));
        // shift larger element up, or drop the key into place
        we = 1'b1;
        if (j != '0 && rdata > key) begin
          waddr = AW'(j);
          wdata = rdata;
        end else begin
          waddr = AW'(j);
          wdata = key;
        end
      end
      S_PICK: raddr = AW'(pick_addr);
      S_MEAN: begin
        dreq.go = 1'b1;
        dreq.dividend = 128'(vsum);
        dreq.divisor  = 32'(count);
      end
      S_VAR1: if (drsp.done) begin
        dreq.go = 1'b1;
        dreq.dividend = diff;
        dreq.divisor  = 32'(count);
      end
      S_VAR2: if (drsp.done) begin
        dreq.go = 1'b1;
        dreq.dividend = drsp.quotient;
        dreq.divisor  = 32'(count);
      end
      default: ;
    endcase
  end

  // bitwise square root: try each result bit from the top
  logic [31:0] rtry;
  logic [63:0] rsq;
  assign rtry = root | (32'h8000_0000 >> step);
  assign rsq  = 64'(rtry) * 64'(rtry);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      vsum   <= '0;
      qsum   <= '0;
      ovf    <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: if (accept) begin
          if (sample_valid) begin
            if (count < CW'(MAX_SAMPLES)) begin
              count <= count + CW'(1);
              vsum  <= vsum + SW'(sample_value);
              qsum  <= qsum + QW'(64'(sample_value) * 64'(sample_value));
            end else begin
              ovf <= 1'b1;
            end
          end
          if (set_end) begin
            i     <= CW'(1);
            state <= S_OUTER;
          end
        end
        S_OUTER: begin
          if (count == '0) begin
            {vmin, vmax, vmed_a, vmed_b, v90, v95, vmean, root} <= '0;
            kind  <= STAT_COUNT;
            state <= S_EMIT;
          end else if (i >= count) begin
            pidx  <= 3'd0;
            state <= S_PICK;
          end else begin
            j     <= i;
            state <= S_RDKEY;
          end
        end
        S_RDKEY: begin
          key   <= rdata;
          state <= S_CMP;
        end
        S_CMP: begin
          // the read of store[j-2] issued here is store[j-1] next cycle
          if (j != '0 && rdata > key) begin
            j     <= j - CW'(1);
          end else begin
            i     <= i + CW'(1);
            state <= S_OUTER;
          end
        end
        S_PICK: state <= S_PWAIT;
        S_PWAIT: begin
          case (pidx)
            3'd0:    vmin   <= rdata;
            3'd1:    vmax   <= rdata;
            3'd2:    vmed_a <= rdata;
            3'd3:    vmed_b <= rdata;
            3'd4:    v90    <= rdata;
            default: v95    <= rdata;
          endcase
          if (pidx == 3'd5) state <= S_MEAN;
          else begin
            pidx  <= pidx + 3'd1;
            state <= S_PICK;
          end
        end
        S_MEAN: state <= S_VAR1;
        S_VAR1: if (drsp.done) begin
          vmean <= drsp.quotient[31:0];
          state <= S_VAR2;
        end
        S_VAR2: if (drsp.done) begin
          state <= S_VAR3;
        end
        S_VAR3: if (drsp.done) begin
          var_v <= drsp.quotient[63:0];
          step  <= 5'd0;
          root  <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (rsq <= var_v) root <= rtry;
          if (step == 5'd31) begin
            kind  <= STAT_COUNT;
            state <= S_EMIT;
          end else begin
            step <= step + 5'd1;
          end
        end
        S_EMIT: begin
          strobe     <= 1'b1;
          stat_kind  <= kind;
          overflowed <= ovf;
          final_stat <= (kind == STAT_STDDEV);
          case (kind)
            STAT_COUNT:  stat_value <= 32'(count);
            STAT_MIN:    stat_value <= vmin;
            STAT_MAX:    stat_value <= vmax;
            STAT_MEAN:   stat_value <= vmean;
            STAT_MEDIAN: stat_value <= count[0] ? vmed_b
                                     : 32'((33'(vmed_a) + 33'(vmed_b)) >> 1);
            STAT_P90:    stat_value <= v90;
            STAT_P95:    stat_value <= v95;
            default:     stat_value <= root;
          endcase
          kind <= kind + 3'd1;
          if (kind == STAT_STDDEV) begin
            // clear the set for the next run
            count <= '0;
            vsum  <= '0;
            qsum  <= '0;
            ovf   <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // final result flag only with the standard deviation kind
  assert property (@(posedge clk) disable iff (rst)
    strobe && final_stat |-> stat_kind == STAT_STDDEV) else $error("final kind");
  assert property (@(posedge clk) disable iff (rst)
    strobe && !final_stat |-> busy) else $error("strobe while idle");
  assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SAMPLES)) else $error("count over capacity");
endmodule

// File: verif/sample_statistics_engine_top_tb.sv
// ----------------------------------------------------------------------------
// sample_statistics_engine_top_tb: self-checking bench for the statistics engine
// Feeds sample sets through the command port with random gaps, predicts the
// eight statistics of each closed set and checks every strobed result in order.
// ----------------------------------------------------------------------------
module sample_statistics_engine_top_tb import sse_pkg::*; ();

  localparam int CAPACITY    = 1024;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int RANDOM_ITEMS = 260;

  typedef struct packed {
    logic [31:0] value;
    logic        valid;
    logic        close;
  } sample_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic        ovf;
    logic        last;
  } stat_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] sample_value;
  logic        sample_valid;
  logic        set_end;
  logic        strobe;
  logic [2:0]  stat_kind;
  logic [31:0] stat_value;
  logic        overflowed;
  logic        final_stat;

  sample_item_t pending_items[$];
  stat_result_t expected_stats[$];
  logic [31:0]  open_set[$];
  logic         open_set_overflow;
  int           mismatch_count;
  int           gap_left;
  bit           gapless_mode;
  int           cycle_count;

  sample_statistics_engine_top #(.MAX_SAMPLES(CAPACITY)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .sample_value(sample_value), .sample_valid(sample_valid), .set_end(set_end),
    .strobe(strobe), .stat_kind(stat_kind), .stat_value(stat_value),
    .overflowed(overflowed), .final_stat(final_stat)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Floor square root of a 64-bit variance, one result bit per step.
  function automatic logic [31:0] floor_sqrt(logic [63:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if ({32'd0, trial} * {32'd0, trial} <= v) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Close the current set: sort, derive all eight statistics, queue them.
  task automatic close_set();
    logic [31:0]  vals[8];
    logic [31:0]  sorted_set[$];
    logic [127:0] sum;
    logic [127:0] square_sum;
    logic [127:0] spread;
    logic [32:0]  mid_pair;
    int           n;
    int           i90;
    int           i95;
    stat_result_t r;
    n = open_set.size();
    foreach (vals[k]) vals[k] = '0;
    if (n > 0) begin
      sorted_set = open_set;
      sorted_set.sort();
      sum = '0;
      square_sum = '0;
      foreach (sorted_set[k]) begin
        sum += sorted_set[k];
        square_sum += {96'd0, sorted_set[k]} * {96'd0, sorted_set[k]};
      end
      i90 = (9 * n) / 10;
      i95 = (19 * n) / 20;
      if (i90 >= n) i90 = n - 1;
      if (i95 >= n) i95 = n - 1;
      vals[STAT_COUNT] = n;
      vals[STAT_MIN]   = sorted_set[0];
      vals[STAT_MAX]   = sorted_set[n-1];
      vals[STAT_MEAN]  = 32'(sum / n);
      if (n % 2 == 0) begin
        mid_pair = {1'b0, sorted_set[n/2-1]} + {1'b0, sorted_set[n/2]};
        vals[STAT_MEDIAN] = mid_pair[32:1];
      end else begin
        vals[STAT_MEDIAN] = sorted_set[n/2];
      end
      vals[STAT_P90] = sorted_set[i90];
      vals[STAT_P95] = sorted_set[i95];
      spread = (n * square_sum - sum * sum) / n / n;
      vals[STAT_STDDEV] = floor_sqrt(spread[63:0]);
    end
    for (int k = 0; k < 8; k++) begin
      r.kind  = 3'(k);
      r.value = vals[k];
      r.ovf   = open_set_overflow;
      r.last  = (3'(k) == STAT_STDDEV);
      expected_stats.push_back(r);
    end
    open_set.delete();
    open_set_overflow = 1'b0;
  endtask

  // Apply one accepted transaction to the predicted state.
  task automatic absorb_item(sample_item_t it);
    if (it.valid) begin
      if (open_set.size() < CAPACITY) begin
        open_set.push_back(it.value);
      end else begin
        open_set_overflow = 1'b1;
      end
    end
    if (it.close) begin
      close_set();
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("MISMATCH t=%0t %s: got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic add_item(logic [31:0] v, logic valid, logic close);
    sample_item_t it;
    it.value = v;
    it.valid = valid;
    it.close = close;
    pending_items.push_back(it);
  endtask

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [31:0] random_sample(int style);
    case (style)
      0: begin
        return $urandom();
      end
      1: begin
        return $urandom_range(255);
      end
      2: begin
        return 32'hFFFF_FFFF - $urandom_range(15);
      end
      default: begin
        return $urandom_range(2000, 1000);
      end
    endcase
  endfunction

  // Driver: hold an item until it is taken, then advance after a random gap.
  always @(posedge clk) begin
    bit taken;
    taken = 1'b0;
    if (rst) begin
      start        <= 1'b0;
      sample_value <= '0;
      sample_valid <= 1'b0;
      set_end      <= 1'b0;
      gap_left     <= 0;
    end else begin
      if (start && !busy) begin
        absorb_item('{sample_value, sample_valid, set_end});
        taken = 1'b1;
      end
      if (!start || taken) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (pending_items.size() > 0) begin
          sample_value <= pending_items[0].value;
          sample_valid <= pending_items[0].valid;
          set_end      <= pending_items[0].close;
          pending_items.pop_front();
          start        <= 1'b1;
          if ($urandom_range(99) < 3) gapless_mode <= ~gapless_mode;
          gap_left     <= gapless_mode ? 0 : pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest expectation.
  always @(posedge clk) begin
    stat_result_t want;
    if (!rst && strobe) begin
      if (expected_stats.size() == 0) begin
        report_mismatch("unexpected result, kind", 32'(stat_kind), 32'd0);
      end else begin
        want = expected_stats.pop_front();
        if (stat_kind != want.kind) begin
          report_mismatch("stat_kind", 32'(stat_kind), 32'(want.kind));
        end
        if (stat_value != want.value) begin
          report_mismatch("stat_value", stat_value, want.value);
        end
        if (overflowed != want.ovf) begin
          report_mismatch("overflowed", 32'(overflowed), 32'(want.ovf));
        end
        if (final_stat != want.last) begin
          report_mismatch("final_stat", 32'(final_stat), 32'(want.last));
        end
      end
    end
  end

  // Watchdog: end the run as failed once it passes CYCLE_LIMIT.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int items_added;
    int set_size;
    int style;
    rst               = 1'b1;
    start             = 1'b0;
    sample_value      = '0;
    sample_valid      = 1'b0;
    set_end           = 1'b0;
    gap_left          = 0;
    gapless_mode      = 1'b0;
    cycle_count       = 0;
    mismatch_count    = 0;
    open_set_overflow = 1'b0;

    // Directed: empty set, idle item, extremes, even and odd medians.
    add_item(32'h0, 1'b0, 1'b1);
    add_item(32'hDEAD_BEEF, 1'b0, 1'b0);
    add_item(32'hFFFF_FFFF, 1'b1, 1'b1);
    add_item(32'h0, 1'b1, 1'b0);
    add_item(32'hFFFF_FFFF, 1'b1, 1'b0);
    add_item(32'h0, 1'b0, 1'b1);
    for (int k = 0; k < 4; k++) add_item(32'hFFFF_FFFF, 1'b1, k == 3);
    add_item(32'd7, 1'b1, 1'b0);
    add_item(32'h1234, 1'b0, 1'b0);
    add_item(32'd3, 1'b1, 1'b0);
    add_item(32'd7, 1'b1, 1'b0);
    add_item(32'd1, 1'b1, 1'b0);
    add_item(32'hFFFF_FFFE, 1'b1, 1'b1);
    for (int k = 0; k < 3; k++) add_item(32'h8000_0000 >> k, 1'b1, k == 2);

    // Random sets, mostly small, with idle noise and empty sets mixed in.
    items_added = pending_items.size();
    while (items_added < RANDOM_ITEMS) begin
      set_size = ($urandom_range(9) == 0) ? $urandom_range(40, 15) : $urandom_range(8);
      style = $urandom_range(3);
      for (int k = 0; k < set_size; k++) begin
        if ($urandom_range(9) == 0) begin
          add_item($urandom(), 1'b0, 1'b0);
          items_added++;
        end
        add_item(random_sample($urandom_range(4) == 0 ? 0 : style), 1'b1, 1'b0);
        items_added++;
      end
      if ($urandom_range(1) == 1) begin
        add_item(random_sample(style), 1'b1, 1'b1);
      end else begin
        add_item($urandom(), 1'b0, 1'b1);
      end
      items_added++;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Wait for every transaction to be taken and every result to arrive.
    @(negedge clk);
    while (pending_items.size() != 0 || start || busy || expected_stats.size() != 0) begin
      @(negedge clk);
    end
    repeat (300) @(posedge clk);

    if (mismatch_count == 0 && expected_stats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// File: files.f
design/sse_pkg.sv
design/sse_divider.sv
design/sample_statistics_engine_top.sv
verif/sample_statistics_engine_top_tb.sv
